// ===== rtl/chb_pkg.sv =====
// Shared constants and the saturation helper for the Chebyshev term generator.
package chb_pkg;

    localparam int POS_W   = 17;
    localparam int NUM_W   = 6;
    localparam int ORDER_W = 5;
    localparam int VAL_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int SUM_W   = 35;
    localparam int FRAC_SH = 29;

    localparam logic [POS_W-1:0] POS_ONE      = 17'h10000;
    localparam logic [NUM_W-1:0] NUM_TERMS_RST = 6'd8;
    localparam logic [NUM_W-1:0] NUM_TERMS_MIN = 6'd2;

    localparam logic signed [VAL_W-1:0] ONE_Q30 = 32'sh4000_0000;
    localparam logic signed [VAL_W-1:0] ONE_Q20 = 32'sh0010_0000;
    localparam logic signed [SUM_W-1:0] SAT_HI  = 35'sh0_4000_0000;
    localparam logic signed [SUM_W-1:0] SAT_LO  = -35'sh0_4000_0000;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Clamp an exact sum to [-2^30, 2^30].
    function automatic val_t sat30(input sum_t v);
        val_t r;
        if (v > SAT_HI)
        begin
            r = ONE_Q30;
        end
        else if (v < SAT_LO)
        begin
            r = -ONE_Q30;
        end
        else
        begin
            r = VAL_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/chb_mul.sv =====
// Shared signed 32x32 multiplier with a registered product.
module chb_mul
(
    input  logic               clk,
    input  logic               en,
    input  chb_pkg::val_t      a,
    input  chb_pkg::val_t      b,
    output chb_pkg::prod_t     prod
);

    chb_pkg::prod_t prod_reg;
    chb_pkg::prod_t prod_next;

    assign prod_next = chb_pkg::PROD_W'(a) * chb_pkg::PROD_W'(b);

    // Hold the product until the sequencer issues the next multiply.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/chebyshev_term_generator_top.sv =====
// Top level: Chebyshev term generator with derivatives, one shared multiplier.
// Each accepted word carries a grid position p (1.0 = 65536, values above
// one clamp to one), mapped to x = 2p - 1 in Q1.30. The block then delivers
// num_terms result words, orders 0 upward: T_k(x) in Q1.30 and T'_k(x) in
// Q11.20, both saturated to +/-2^30, with last_order on the final order and
// grid_done on it too when the input word had grid_end set. num_terms is
// clamped to [2, MAX_TERMS] when a position is accepted. Orders 0 and 1 are
// seeded directly in S_SEED; every higher order passes through S_MT, S_MD
// and S_EMIT, because the single 32x32 multiplier is used twice per order
// (x*T(k-1), then x*T'(k-1)) and its product is registered. A position holds
// the block from acceptance to its last order, longer when the output side
// stalls. in_ready is high only between positions; a finished result
// sits in the output register while work on the next order continues.
module chebyshev_term_generator_top
#(
    parameter int MAX_TERMS = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [chb_pkg::NUM_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [chb_pkg::POS_W-1:0]           position,
    input  logic                                grid_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [chb_pkg::ORDER_W-1:0]         order,
    output logic signed [chb_pkg::VAL_W-1:0]    poly_value,
    output logic signed [chb_pkg::VAL_W-1:0]    slope_value,
    output logic                                last_order,
    output logic                                grid_done
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a position word
    localparam logic [2:0] S_SEED = 3'd1;  // orders 0 and 1, no multiply
    localparam logic [2:0] S_MT   = 3'd2;  // issue x*T(k-1)
    localparam logic [2:0] S_MD   = 3'd3;  // finish T_k, issue x*T'(k-1)
    localparam logic [2:0] S_EMIT = 3'd4;  // finish T'_k and emit

    localparam int NW = chb_pkg::NUM_W;

    logic [2:0]    state_reg, state_next;
    logic [NW-1:0] num_terms_reg;
    logic [NW-1:0] k_reg;
    logic [NW-1:0] n_reg;
    logic          gend_reg;
    chb_pkg::val_t x_reg;
    chb_pkg::val_t t1_reg, t2_reg, d1_reg, d2_reg;
    chb_pkg::val_t tnew_reg;

    logic [chb_pkg::ORDER_W-1:0] order_reg;
    chb_pkg::val_t               poly_reg, slope_reg;
    logic                        out_valid_reg, last_reg, done_reg;

    // Input side.
    logic [chb_pkg::POS_W-1:0] pos_clamped;
    logic [NW-1:0]             n_clamped;
    chb_pkg::val_t             x_next;
    logic                      in_fire;

    // Shared multiplier.
    logic           mul_en;
    chb_pkg::val_t  mul_b;
    chb_pkg::prod_t prod;

    // Term datapath.
    chb_pkg::sum_t  prod_fl;
    chb_pkg::sum_t  t_sum, d_sum;
    chb_pkg::val_t  term_t, term_d;
    logic           term_ready;
    logic           out_load;
    logic           is_last;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign pos_clamped = (position > chb_pkg::POS_ONE) ? chb_pkg::POS_ONE : position;
    assign x_next = chb_pkg::val_t'({pos_clamped, 15'b0} - 32'h4000_0000);

    always_comb
    begin
        if (num_terms_reg < chb_pkg::NUM_TERMS_MIN)
        begin
            n_clamped = chb_pkg::NUM_TERMS_MIN;
        end
        else if ({1'b0, num_terms_reg} > (NW + 1)'(MAX_TERMS))
        begin
            n_clamped = NW'(MAX_TERMS);
        end
        else
        begin
            n_clamped = num_terms_reg;
        end
    end

    // Operand b selects T(k-1) for the polynomial step, T'(k-1) for the slope.
    assign mul_en = (state_reg == S_MT) || (state_reg == S_MD);
    assign mul_b  = (state_reg == S_MD) ? d1_reg : t1_reg;

    chb_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (x_reg),
        .b    (mul_b),
        .prod (prod)
    );

    // Floor of product / 2^29 is the top bits of the product.
    assign prod_fl = chb_pkg::sum_t'(prod[chb_pkg::PROD_W-1:chb_pkg::FRAC_SH]);
    assign t_sum   = prod_fl - chb_pkg::sum_t'(t2_reg);
    assign d_sum   = chb_pkg::sum_t'(t1_reg >>> 9) + prod_fl
                     - chb_pkg::sum_t'(d2_reg);

    always_comb
    begin
        term_ready = 1'b0;
        term_t     = tnew_reg;
        term_d     = chb_pkg::sat30(d_sum);
        case (state_reg)
            S_SEED:
            begin
                term_ready = 1'b1;
                if (k_reg == '0)
                begin
                    term_t = chb_pkg::ONE_Q30;
                    term_d = '0;
                end
                else
                begin
                    term_t = x_reg;
                    term_d = chb_pkg::ONE_Q20;
                end
            end
            S_EMIT:
            begin
                term_ready = 1'b1;
            end
            default:
            begin
                term_ready = 1'b0;
            end
        endcase
    end

    // Load a ready term into the output register whenever it is empty or being drained.
    assign out_load = term_ready && (!out_valid_reg || out_ready);
    assign is_last  = (k_reg + NW'(1) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED, S_EMIT:
            begin
                if (out_load)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (state_reg == S_SEED && k_reg == '0)
                    begin
                        state_next = S_SEED;
                    end
                    else
                    begin
                        state_next = S_MT;
                    end
                end
            end
            S_MT:
            begin
                state_next = S_MD;
            end
            S_MD:
            begin
                state_next = S_EMIT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_terms_reg <= chb_pkg::NUM_TERMS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                num_terms_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and recurrence history need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg    <= x_next;
            n_reg    <= n_clamped;
            gend_reg <= grid_end;
            k_reg    <= '0;
        end
        if (state_reg == S_MD)
        begin
            tnew_reg <= chb_pkg::sat30(t_sum);
        end
        if (out_load)
        begin
            order_reg <= k_reg[chb_pkg::ORDER_W-1:0];
            poly_reg  <= term_t;
            slope_reg <= term_d;
            last_reg  <= is_last;
            done_reg  <= is_last && gend_reg;
            // Advance the recurrence window.
            t2_reg    <= t1_reg;
            t1_reg    <= term_t;
            d2_reg    <= d1_reg;
            d1_reg    <= term_d;
            k_reg     <= k_reg + NW'(1);
        end
    end

    assign out_valid   = out_valid_reg;
    assign order       = order_reg;
    assign poly_value  = poly_reg;
    assign slope_value = slope_reg;
    assign last_order  = last_reg;
    assign grid_done   = done_reg;

endmodule

// ===== rtl/chb_checker.sv =====
// Port-level checks for the Chebyshev term generator, bound to the top level.
module chb_checker
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [chb_pkg::ORDER_W-1:0]      order,
    input logic signed [chb_pkg::VAL_W-1:0] poly_value,
    input logic signed [chb_pkg::VAL_W-1:0] slope_value,
    input logic                             last_order,
    input logic                             grid_done
);

    // A stalled word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(poly_value)
            && $stable(slope_value) && $stable(order))
        else $error("output word changed while stalled");

    // Busy after a position is taken.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a position");

    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && grid_done |-> last_order)
        else $error("grid_done without last_order");

    a_poly_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> poly_value <= chb_pkg::ONE_Q30 && poly_value >= -chb_pkg::ONE_Q30)
        else $error("poly_value out of saturation range");

    a_slope_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> slope_value <= chb_pkg::ONE_Q30 && slope_value >= -chb_pkg::ONE_Q30)
        else $error("slope_value out of saturation range");

endmodule

bind chebyshev_term_generator_top chb_checker u_chb_checker (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the Chebyshev term generator.
`timescale 1ns / 1ps

module tb_top;

    localparam int     TERM_CAP    = 32;
    localparam int     PHASES      = 8;
    localparam int     PHASE_ITEMS = 52;
    localparam int     LONG_HOLD   = 400;
    localparam int     TAIL_CYCLES = 120;
    localparam int     QUIET_LIMIT = 2000;
    localparam longint Q30_LIM     = 64'sd1073741824;
    localparam longint Q20_ONE     = 64'sd1048576;

    // One position word as the sender offers it.
    typedef struct {
        logic [chb_pkg::POS_W-1:0] pos;
        logic                      gend;
    } pos_word_t;

    // One result word as the block must deliver it.
    typedef struct {
        logic [chb_pkg::ORDER_W-1:0]      order;
        logic signed [chb_pkg::VAL_W-1:0] poly;
        logic signed [chb_pkg::VAL_W-1:0] slope;
        logic                             last_ord;
        logic                             grid_fin;
    } term_t;

    logic                             clk         = 1'b0;
    logic                             rst_n       = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [chb_pkg::NUM_W-1:0]        cfg_wr_data = '0;
    logic                             in_valid    = 1'b0;
    logic                             in_ready;
    logic [chb_pkg::POS_W-1:0]        position    = '0;
    logic                             grid_end    = 1'b0;
    logic                             out_valid;
    logic                             out_ready   = 1'b0;
    logic [chb_pkg::ORDER_W-1:0]      order;
    logic signed [chb_pkg::VAL_W-1:0] poly_value;
    logic signed [chb_pkg::VAL_W-1:0] slope_value;
    logic                             last_order;
    logic                             grid_done;

    pos_word_t                 pos_q[$];     // positions waiting to be offered
    term_t                     term_q[$];    // terms owed by the block, oldest first
    term_t                     got_term;
    pos_word_t                 next_word;
    logic [chb_pkg::NUM_W-1:0] terms_cfg = chb_pkg::NUM_TERMS_RST;

    logic in_taken     = 1'b0;
    bit   send_idle_on = 1'b0;
    bit   recv_idle_on = 1'b0;
    bit   hold_req     = 1'b0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;
    int   fail_cnt     = 0;

    chebyshev_term_generator_top #(
        .MAX_TERMS   (TERM_CAP)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .position    (position),
        .grid_end    (grid_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .order       (order),
        .poly_value  (poly_value),
        .slope_value (slope_value),
        .last_order  (last_order),
        .grid_done   (grid_done)
    );

    always #5 clk = ~clk;

    // Clamp an exact sum to [-2^30, 2^30].
    function automatic longint clamp_q30(input longint v);
        if (v > Q30_LIM)
        begin
            return Q30_LIM;
        end
        if (v < -Q30_LIM)
        begin
            return -Q30_LIM;
        end
        return v;
    endfunction

    // Run the recurrence for one accepted position and queue every term it owes.
    // Arithmetic shifts on 64-bit signed values give the floor the block uses.
    function automatic void expand_position(input logic [chb_pkg::POS_W-1:0] pos,
                                            input logic gend);
        longint      x;
        longint      t;
        longint      d;
        longint      t1;
        longint      t2;
        longint      d1;
        longint      d2;
        int unsigned n;
        term_t       e;
        t1 = 0;
        t2 = 0;
        d1 = 0;
        d2 = 0;
        t  = 0;
        d  = 0;
        n  = terms_cfg;
        // Clamp the term count to the range the block supports.
        if (n < chb_pkg::NUM_TERMS_MIN)
        begin
            n = chb_pkg::NUM_TERMS_MIN;
        end
        if (n > TERM_CAP)
        begin
            n = TERM_CAP;
        end
        // Positions above one behave as exactly one.
        if (pos > chb_pkg::POS_ONE)
        begin
            x = Q30_LIM;
        end
        else
        begin
            x = longint'(pos) * 32768 - Q30_LIM;
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            if (k == 0)
            begin
                t = Q30_LIM;
                d = 0;
            end
            else if (k == 1)
            begin
                t = x;
                d = Q20_ONE;
            end
            else
            begin
                t = clamp_q30(((x * t1) >>> 29) - t2);
                d = clamp_q30((t1 >>> 9) + ((x * d1) >>> 29) - d2);
            end
            e.order    = chb_pkg::ORDER_W'(k);
            e.poly     = chb_pkg::VAL_W'(t);
            e.slope    = chb_pkg::VAL_W'(d);
            e.last_ord = (k + 1 == n);
            e.grid_fin = (k + 1 == n) && gend;
            term_q = {term_q, e};
            t2 = t1;
            t1 = t;
            d2 = d1;
            d1 = d;
        end
    endfunction

    function automatic void check_field(input string name, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    task automatic queue_position(input logic [chb_pkg::POS_W-1:0] pos, input logic gend);
        pos_word_t w;
        w.pos  = pos;
        w.gend = gend;
        pos_q  = {pos_q, w};
    endtask

    // Queue an ascending grid of n positions ending at one with the end mark set.
    task automatic queue_grid(input int unsigned n);
        int unsigned step;
        step = 65536 / (n - 1);
        for (int unsigned i = 0; i + 1 < n; i++)
        begin
            queue_position(chb_pkg::POS_W'(i * step + $urandom_range(0, step / 2)), 1'b0);
        end
        queue_position(chb_pkg::POS_ONE, 1'b1);
    endtask

    // Write num_terms while the block is idle and track it for prediction.
    task automatic write_terms(input logic [chb_pkg::NUM_W-1:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        terms_cfg = v;
    endtask

    // Hold until every queued position is taken and every owed term has arrived.
    task automatic drain();
        do
        begin
            @(posedge clk);
        end
        while (pos_q.size() != 0 || in_valid || term_q.size() != 0);
    endtask

    // Driver: offer the next word once the current one is taken; idle in bursts.
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (send_idle_on && pos_q.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 10) - 1;
                in_valid <= 1'b0;
            end
            else if (pos_q.size() != 0)
            begin
                next_word = pos_q.pop_front();
                in_valid <= 1'b1;
                position <= next_word.pos;
                grid_end <= next_word.gend;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a requested long hold first, then random stall bursts.
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (recv_idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 10) - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: predict on each taken position, check each delivered term.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                expand_position(position, grid_end);
            end
            if (out_valid && out_ready)
            begin
                if (term_q.size() == 0)
                begin
                    $error("result word with no term owed: order %0d", order);
                    fail_cnt++;
                end
                else
                begin
                    got_term = term_q.pop_front();
                    check_field("order", got_term.order, order);
                    check_field("poly_value", got_term.poly, poly_value);
                    check_field("slope_value", got_term.slope, slope_value);
                    check_field("last_order", got_term.last_ord, last_order);
                    check_field("grid_done", got_term.grid_fin, grid_done);
                end
            end
        end
    end

    // Watchdog: end the run if no word moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        int                        ph;
        int                        queued;
        int unsigned               n;
        logic [chb_pkg::NUM_W-1:0] cfg_val;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        // Reset count of 8: both ends of x, the middle, and the all-ones position.
        queue_position(17'd0, 1'b0);
        queue_position(chb_pkg::POS_ONE, 1'b1);
        queue_position(17'd32768, 1'b0);
        queue_position(17'h1FFFF, 1'b1);
        drain();

        // Fewest terms.
        write_terms(6'd2);
        queue_position(17'd0, 1'b0);
        queue_position(chb_pkg::POS_ONE, 1'b0);
        queue_position(17'd1, 1'b1);
        drain();

        // Most terms, near both ends where derivatives grow largest.
        write_terms(6'd32);
        queue_position(17'd0, 1'b0);
        queue_position(chb_pkg::POS_ONE, 1'b0);
        queue_position(17'd65535, 1'b0);
        queue_position(17'd1, 1'b0);
        queue_position(17'd32768, 1'b1);
        drain();

        // Counts below two behave as two.
        write_terms(6'd0);
        queue_position(17'd16384, 1'b0);
        queue_position(17'd65537, 1'b1);
        drain();
        write_terms(6'd1);
        queue_position(17'd49152, 1'b1);
        drain();

        // Counts above the cap behave as the cap.
        write_terms(6'd33);
        queue_position(17'd12345, 1'b0);
        queue_position(17'd65536, 1'b1);
        drain();
        write_terms(6'd63);
        queue_position(17'd40000, 1'b0);
        queue_position(17'h1FFFF, 1'b1);
        drain();

        // Random phases: mostly whole grids, the rest loose positions.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       cfg_val = 6'd2;
                1:       cfg_val = 6'd32;
                default: cfg_val = chb_pkg::NUM_W'($urandom_range(0, 63));
            endcase
            // The final phase runs with no idling on either side.
            send_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            recv_idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
            write_terms(cfg_val);
            queued = 0;
            while (queued < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    n = $urandom_range(2, 12);
                    queue_grid(n);
                    queued += n;
                end
                else
                begin
                    queue_position(chb_pkg::POS_W'($urandom_range(0, 131071)),
                                   1'($urandom_range(0, 1)));
                    queued++;
                end
            end
            // Stall the output for a long stretch so the block backs up its input.
            if (ph == 2)
            begin
                hold_req = 1'b1;
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && term_q.size() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chb_pkg.sv
rtl/chb_mul.sv
rtl/chebyshev_term_generator_top.sv
rtl/chb_checker.sv
sim/tb_top.sv
